FILE: rtl/bieu_pkg.sv
package bieu_pkg;

    localparam int XLEN = 64;
    localparam int TLEN = 32;

    localparam logic [XLEN-1:0] XMIN  = {1'b1, {(XLEN-1){1'b0}}};
    localparam logic [XLEN-1:0] XNEG1 = {XLEN{1'b1}};

    typedef enum logic [4:0] {
        F_CONST  = 5'd0,
        F_BCONST = 5'd1,
        F_MOV    = 5'd2,
        F_ADD    = 5'd3,
        F_SUB    = 5'd4,
        F_MUL    = 5'd5,
        F_DIV    = 5'd6,
        F_MOD    = 5'd7,
        F_NEG    = 5'd8,
        F_EQ     = 5'd9,
        F_NEQ    = 5'd10,
        F_LT     = 5'd11,
        F_LTE    = 5'd12,
        F_GT     = 5'd13,
        F_GTE    = 5'd14,
        F_NOT    = 5'd15,
        F_AND    = 5'd16,
        F_OR     = 5'd17,
        F_JMP    = 5'd18,
        F_JMPF   = 5'd19,
        F_JMPT   = 5'd20,
        F_RET    = 5'd21
    } func_t;

    typedef enum logic [2:0] {
        ST_DONE  = 3'd0,
        ST_JUMP  = 3'd1,
        ST_RET   = 3'd2,
        ST_UNSUP = 3'd3,
        ST_DIVF  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_WB
    } state_t;

    typedef struct packed {
        status_t           status;
        logic [XLEN-1:0]   value;
        logic [TLEN-1:0]   jump_to;
        logic              we;
    } exec_res_t;

endpackage

FILE: rtl/bieu_instr_if.sv
interface bieu_instr_if;
    logic               valid;
    logic               ready;
    logic [4:0]         func;
    logic [7:0]         dest_reg;
    logic [7:0]         src_a;
    logic [7:0]         src_b;
    logic signed [63:0] immediate;
    logic [31:0]        target;

    modport source
    (
        output valid, func, dest_reg, src_a, src_b, immediate, target,
        input  ready
    );

    modport sink
    (
        input  valid, func, dest_reg, src_a, src_b, immediate, target,
        output ready
    );
endinterface

FILE: rtl/bieu_result_if.sv
interface bieu_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [63:0] value;
    logic [31:0]        jump_to;

    modport source
    (
        output valid, status, value, jump_to,
        input  ready
    );

    modport sink
    (
        input  valid, status, value, jump_to,
        output ready
    );
endinterface

FILE: rtl/bieu_regfile.sv
module bieu_regfile #(
    parameter int NUM_REGS = 256,
    parameter int AW       = 8
)
(
    input  logic                   clk,
    input  logic                   re,
    input  logic [AW-1:0]          raddr_a,
    input  logic [AW-1:0]          raddr_b,
    output logic [bieu_pkg::XLEN-1:0] rdata_a,
    output logic [bieu_pkg::XLEN-1:0] rdata_b,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [bieu_pkg::XLEN-1:0] wdata
);
    import bieu_pkg::*;

    logic [XLEN-1:0] mem [NUM_REGS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end
endmodule

FILE: rtl/bieu_mul.sv
module bieu_mul
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bieu_pkg::XLEN-1:0] a,
    input  logic [bieu_pkg::XLEN-1:0] b,
    output logic                      done,
    output logic [bieu_pkg::XLEN-1:0] product
);
    import bieu_pkg::*;

    localparam int HW = XLEN / 2;

    logic            busy_reg;
    logic [1:0]      step_reg;
    logic            done_reg;
    logic [XLEN-1:0] a_reg;
    logic [XLEN-1:0] b_reg;
    logic [XLEN-1:0] prod_reg;
    logic [XLEN-1:0] acc_reg;
    logic [HW-1:0]   op_x;
    logic [HW-1:0]   op_y;
    logic [XLEN-1:0] prod_next;

    // partial products: lo*lo, lo*hi, hi*lo; hi*hi falls outside 64 bits
    always_comb
    begin
        op_x      = (step_reg == 2'd2) ? a_reg[XLEN-1:HW] : a_reg[HW-1:0];
        op_y      = (step_reg == 2'd1) ? b_reg[XLEN-1:HW] : b_reg[HW-1:0];
        prod_next = {{HW{1'b0}}, op_x} * {{HW{1'b0}}, op_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (busy_reg)
        begin
            if (step_reg != 2'd3)
            begin
                prod_reg <= prod_next;
            end
            case (step_reg)
                2'd1:    acc_reg <= prod_reg;
                2'd2,
                2'd3:    acc_reg <= acc_reg + {prod_reg[HW-1:0], {HW{1'b0}}};
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

FILE: rtl/bieu_div.sv
module bieu_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bieu_pkg::XLEN-1:0] a,
    input  logic [bieu_pkg::XLEN-1:0] b,
    output logic                      done,
    output logic [bieu_pkg::XLEN-1:0] quotient,
    output logic [bieu_pkg::XLEN-1:0] remainder
);
    import bieu_pkg::*;

    localparam int CW = $clog2(XLEN);

    logic            busy_reg;
    logic [CW-1:0]   cnt_reg;
    logic            done_reg;
    logic [XLEN-1:0] quo_reg;
    logic [XLEN-1:0] rem_reg;
    logic [XLEN-1:0] den_reg;
    logic            qneg_reg;
    logic            rneg_reg;
    logic [XLEN:0]   rem_sh;
    logic [XLEN:0]   diff;

    // restoring divide on magnitudes, one quotient bit per cycle
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[XLEN-1]};
        diff   = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(XLEN - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= a[XLEN-1] ? (XLEN'(0) - a) : a;
            den_reg  <= b[XLEN-1] ? (XLEN'(0) - b) : b;
            rem_reg  <= '0;
            qneg_reg <= a[XLEN-1] ^ b[XLEN-1];
            rneg_reg <= a[XLEN-1];
        end
        else if (busy_reg)
        begin
            if (!diff[XLEN])
            begin
                rem_reg <= diff[XLEN-1:0];
                quo_reg <= {quo_reg[XLEN-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[XLEN-1:0];
                quo_reg <= {quo_reg[XLEN-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? (XLEN'(0) - quo_reg) : quo_reg;
    assign remainder = rneg_reg ? (XLEN'(0) - rem_reg) : rem_reg;
endmodule

FILE: rtl/bytecode_integer_execute_unit.sv
// Most instructions read the register file, then execute and write back; mul runs a 32x32
// multiplier over three partial products, then writes back; div/mod compute 64 quotient bits,
// one per cycle, then write back; a result that finds the output full waits until it is taken.
// One instruction in flight; the next is accepted the cycle after the result enters the
// output register.
// Reset: rst_n async low clears control and program_length; register file is not cleared.
module bytecode_integer_execute_unit #(
    parameter int NUM_REGS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    bieu_instr_if.sink  instr,
    bieu_result_if.source result,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data
);
    import bieu_pkg::*;

    localparam int         AW      = $clog2(NUM_REGS);
    localparam logic [8:0] IDX_LIM = 9'(NUM_REGS);

    state_t          state_reg;
    state_t          state_next;
    logic [TLEN-1:0] prog_len_reg;

    logic [4:0]      func_reg;
    logic [AW-1:0]   dst_idx_reg;
    logic            dst_ok_reg;
    logic            a_ok_reg;
    logic            b_ok_reg;
    logic [XLEN-1:0] imm_reg;
    logic [TLEN-1:0] target_reg;

    logic [XLEN-1:0] rdata_a;
    logic [XLEN-1:0] rdata_b;
    logic [XLEN-1:0] opa;
    logic [XLEN-1:0] opb;

    exec_res_t       exec_res;
    exec_res_t       hold_reg;
    exec_res_t       cur;
    logic            is_mul;
    logic            is_div;
    logic            div_fault;
    logic            in_range;

    logic            accept;
    logic            out_free;
    logic            commit;
    logic            hold_load;
    logic            mul_start;
    logic            div_start;
    logic            mul_done;
    logic            div_done;
    logic [XLEN-1:0] mul_prod;
    logic [XLEN-1:0] div_quo;
    logic [XLEN-1:0] div_rem;
    logic            rf_we;

    logic            out_valid_reg;
    logic [2:0]      out_status_reg;
    logic [XLEN-1:0] out_value_reg;
    logic [TLEN-1:0] out_jump_reg;

    assign accept   = instr.valid && instr.ready;
    assign out_free = !out_valid_reg || result.ready;

    bieu_regfile #(
        .NUM_REGS (NUM_REGS),
        .AW       (AW)
    ) u_regfile (
        .clk     (clk),
        .re      (accept),
        .raddr_a (instr.src_a[AW-1:0]),
        .raddr_b (instr.src_b[AW-1:0]),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .we      (rf_we),
        .waddr   (dst_idx_reg),
        .wdata   (cur.value)
    );

    bieu_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (opa),
        .b       (opb),
        .done    (mul_done),
        .product (mul_prod)
    );

    bieu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .a         (opa),
        .b         (opb),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_len_reg <= '0;
        end
        else if (cfg_we)
        begin
            prog_len_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= instr.func;
            dst_idx_reg <= instr.dest_reg[AW-1:0];
            dst_ok_reg  <= {1'b0, instr.dest_reg} < IDX_LIM;
            a_ok_reg    <= {1'b0, instr.src_a} < IDX_LIM;
            b_ok_reg    <= {1'b0, instr.src_b} < IDX_LIM;
            imm_reg     <= instr.immediate;
            target_reg  <= instr.target;
        end
    end

    always_comb
    begin
        opa       = a_ok_reg ? rdata_a : '0;
        opb       = b_ok_reg ? rdata_b : '0;
        in_range  = target_reg < prog_len_reg;
        div_fault = (opb == '0) || (opa == XMIN && opb == XNEG1);
        is_mul    = func_reg == F_MUL;
        is_div    = (func_reg == F_DIV || func_reg == F_MOD) && !div_fault;

        exec_res.status  = ST_DONE;
        exec_res.value   = '0;
        exec_res.jump_to = '0;
        exec_res.we      = 1'b1;
        unique case (func_reg) inside
            F_CONST:  exec_res.value = imm_reg;
            F_BCONST: exec_res.value = XLEN'(imm_reg != '0);
            F_MOV:    exec_res.value = opa;
            F_ADD:    exec_res.value = opa + opb;
            F_SUB:    exec_res.value = opa - opb;
            F_MUL:    exec_res.value = '0;
            F_DIV, F_MOD:
            begin
                exec_res.status = ST_DIVF;
                exec_res.we     = 1'b0;
            end
            F_NEG:    exec_res.value = XLEN'(0) - opa;
            F_EQ:     exec_res.value = XLEN'(opa == opb);
            F_NEQ:    exec_res.value = XLEN'(opa != opb);
            F_LT:     exec_res.value = XLEN'($signed(opa) <  $signed(opb));
            F_LTE:    exec_res.value = XLEN'($signed(opa) <= $signed(opb));
            F_GT:     exec_res.value = XLEN'($signed(opa) >  $signed(opb));
            F_GTE:    exec_res.value = XLEN'($signed(opa) >= $signed(opb));
            F_NOT:    exec_res.value = XLEN'(opa == '0);
            F_AND:    exec_res.value = XLEN'((opa != '0) && (opb != '0));
            F_OR:     exec_res.value = XLEN'((opa != '0) || (opb != '0));
            F_JMP, F_JMPF, F_JMPT:
            begin
                exec_res.we = 1'b0;
                if (in_range && (func_reg == F_JMP
                                 || (func_reg == F_JMPF && opa == '0)
                                 || (func_reg == F_JMPT && opa != '0)))
                begin
                    exec_res.status  = ST_JUMP;
                    exec_res.jump_to = target_reg;
                end
            end
            F_RET:
            begin
                exec_res.we     = 1'b0;
                exec_res.status = ST_RET;
                exec_res.value  = opa;
            end
            default:
            begin
                exec_res.we     = 1'b0;
                exec_res.status = ST_UNSUP;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (is_mul)
                begin
                    state_next = S_MUL;
                end
                else if (is_div)
                begin
                    state_next = S_DIV;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    state_next = S_WB;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        instr.ready = 1'b0;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        commit      = 1'b0;
        hold_load   = 1'b0;
        cur         = exec_res;
        unique case (state_reg)
            S_IDLE:
            begin
                instr.ready = 1'b1;
            end
            S_EXEC:
            begin
                mul_start = is_mul;
                div_start = is_div;
                commit    = !is_mul && !is_div && out_free;
                hold_load = !is_mul && !is_div && !out_free;
            end
            S_MUL, S_DIV:
            begin
            end
            S_WB:
            begin
                cur    = hold_reg;
                commit = out_free;
            end
            default:
            begin
            end
        endcase
        rf_we = commit && cur.we && dst_ok_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_load)
        begin
            hold_reg <= exec_res;
        end
        else if (state_reg == S_MUL && mul_done)
        begin
            hold_reg.status  <= ST_DONE;
            hold_reg.value   <= mul_prod;
            hold_reg.jump_to <= '0;
            hold_reg.we      <= 1'b1;
        end
        else if (state_reg == S_DIV && div_done)
        begin
            hold_reg.status  <= ST_DONE;
            hold_reg.value   <= (func_reg == F_MOD) ? div_rem : div_quo;
            hold_reg.jump_to <= '0;
            hold_reg.we      <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_status_reg <= cur.status;
            out_value_reg  <= cur.value;
            out_jump_reg   <= cur.jump_to;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.status  = out_status_reg;
    assign result.value   = out_value_reg;
    assign result.jump_to = out_jump_reg;

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!out_valid_reg || result.ready))
        else $error("result beat loaded over an untaken beat");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted beat did not enter execute");

    a_divf_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && cur.status == ST_DIVF) |-> !rf_we)
        else $error("divide fault wrote the register file");

    a_unit_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_done |-> state_reg == S_MUL) and (div_done |-> state_reg == S_DIV))
        else $error("arithmetic unit finished outside its state");
endmodule
